### rtl/hsrd_pkg.sv
// hsrd_pkg: shared types, constants and the CRC-8 byte step for the
// sensor readout decoder. No dependencies.
`default_nettype none

package hsrd_pkg;

    // queue between front and back
    localparam int HSRD_QDEPTH = 2;

    // CRC-8, poly 0x31 (0x131 with implicit top bit), init 0xFF
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;

    // conversion constants
    localparam logic [15:0] STATUS_MASK = 16'hFFFC;
    localparam logic [14:0] K_TEMP      = 15'd17500;
    localparam logic [14:0] K_HUM       = 15'd10000;
    localparam logic [14:0] T_OFFSET    = 15'd4500;
    localparam int          PROD_W      = 31;

    // quantity codes
    localparam logic QTY_TEMP = 1'b0;
    localparam logic QTY_HUM  = 1'b1;

    // one completed group: quantity, word and CRC verdict
    typedef struct packed {
        logic        quantity;
        logic        crc_ok;
        logic [15:0] word;
    } t_grp_item;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/hsrd_front.sv
// hsrd_front: byte position tracking, CRC-8 accumulation and word assembly.
// Depends on hsrd_pkg.
`default_nettype none

module hsrd_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire  [7:0]            i_rx_byte,
    input  wire                   i_frame_start,
    output logic                  o_push,
    output hsrd_pkg::t_grp_item   o_push_item
);
    import hsrd_pkg::*;

    typedef enum logic [1:0] {SUB_HI, SUB_LO, SUB_CRC} t_sub;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_word, n_word;
    logic [2:0]  pos_eff;
    t_sub        sub;
    logic        grp;

    always_comb begin
        pos_eff = i_frame_start ? 3'd0 : r_pos;
        unique case (pos_eff)
            3'd0:    begin sub = SUB_HI;  grp = QTY_TEMP; end
            3'd1:    begin sub = SUB_LO;  grp = QTY_TEMP; end
            3'd2:    begin sub = SUB_CRC; grp = QTY_TEMP; end
            3'd3:    begin sub = SUB_HI;  grp = QTY_HUM;  end
            3'd4:    begin sub = SUB_LO;  grp = QTY_HUM;  end
            3'd5:    begin sub = SUB_CRC; grp = QTY_HUM;  end
            default: begin sub = SUB_HI;  grp = QTY_TEMP; pos_eff = 3'd0; end
        endcase

        n_pos  = r_pos;
        n_crc  = r_crc;
        n_word = r_word;
        if (i_accept) begin
            unique case (sub)
                SUB_HI: begin
                    n_crc  = crc8_byte(CRC_INIT, i_rx_byte);
                    n_word = {i_rx_byte, r_word[7:0]};
                    n_pos  = pos_eff + 3'd1;
                end
                SUB_LO: begin
                    n_crc  = crc8_byte(r_crc, i_rx_byte);
                    n_word = {r_word[15:8], i_rx_byte};
                    n_pos  = pos_eff + 3'd1;
                end
                default: begin
                    n_crc = CRC_INIT;
                    n_pos = (pos_eff == 3'd5) ? 3'd0 : pos_eff + 3'd1;
                end
            endcase
        end

        o_push               = i_accept && (sub == SUB_CRC);
        o_push_item.quantity = grp;
        o_push_item.crc_ok   = (r_crc == i_rx_byte);
        o_push_item.word     = r_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_crc  <= CRC_INIT;
            r_word <= 16'd0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

### rtl/hsrd_queue.sv
// hsrd_queue: small FIFO of completed groups between front and back.
// Depends on hsrd_pkg.
`default_nettype none

module hsrd_queue #(
    parameter int DEPTH = hsrd_pkg::HSRD_QDEPTH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  hsrd_pkg::t_grp_item   i_push_item,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output hsrd_pkg::t_grp_item   o_pop_item,
    input  wire                   i_pop
);
    import hsrd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_grp_item   r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/hsrd_back.sv
// hsrd_back: scale multiply, divide by 65535, held-value update, result register.
// Depends on hsrd_pkg.
`default_nettype none

module hsrd_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  hsrd_pkg::t_grp_item   i_item,
    output logic                  o_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic                  o_quantity,
    output logic                  o_crc_ok,
    output logic signed [14:0]    o_value
);
    import hsrd_pkg::*;

    // stage A: scaled product
    logic              r_a_vld;
    logic              r_a_qty;
    logic              r_a_ok;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [15:0]       raw;
    logic [14:0]       k;

    // stage B: held values and output register
    logic [14:0]       r_temp;
    logic [13:0]       r_hum;
    logic              r_out_vld;
    logic              r_out_qty;
    logic              r_out_ok;
    logic [14:0]       r_out_val;
    logic [14:0]       n_out_val;

    logic [PROD_W-1:0] div_sum;
    logic [14:0]       quot;
    logic [14:0]       temp_new;
    logic [13:0]       hum_new;
    logic              adv_b;
    logic              adv_a;

    assign adv_b   = !r_out_vld || i_out_ready;
    assign adv_a   = !r_a_vld || adv_b;
    assign o_ready = adv_a;

    assign raw    = i_item.word & STATUS_MASK;
    assign k      = (i_item.quantity == QTY_HUM) ? K_HUM : K_TEMP;
    assign n_prod = PROD_W'(raw) * PROD_W'(k);

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for quotients below 2^16
    assign div_sum  = r_prod + PROD_W'(r_prod[PROD_W-1:16]) + PROD_W'(1);
    assign quot     = div_sum[PROD_W-1:16];
    assign temp_new = quot - T_OFFSET;
    assign hum_new  = quot[13:0];

    always_comb begin
        if (r_a_qty == QTY_HUM) begin
            n_out_val = {1'b0, r_a_ok ? hum_new : r_hum};
        end else begin
            n_out_val = r_a_ok ? temp_new : r_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_temp    <= 15'd0;
            r_hum     <= 14'd0;
        end else begin
            if (adv_a) begin
                r_a_vld <= i_valid;
            end
            if (adv_b) begin
                r_out_vld <= r_a_vld;
                if (r_a_vld && r_a_ok) begin
                    if (r_a_qty == QTY_HUM) begin
                        r_hum <= hum_new;
                    end else begin
                        r_temp <= temp_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_a_qty <= i_item.quantity;
            r_a_ok  <= i_item.crc_ok;
            r_prod  <= n_prod;
        end
        if (adv_b && r_a_vld) begin
            r_out_qty <= r_a_qty;
            r_out_ok  <= r_a_ok;
            r_out_val <= n_out_val;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_quantity  = r_out_qty;
    assign o_crc_ok    = r_out_ok;
    assign o_value     = $signed(r_out_val);

endmodule

`default_nettype wire

### rtl/humidity_sensor_readout_decoder.sv
// humidity_sensor_readout_decoder: top level of the sensor readout decoder.
// Depends on hsrd_pkg, hsrd_front, hsrd_queue, hsrd_back.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------------
//  in      | i_in_valid / o_in_ready   | i_rx_byte[7:0], i_frame_start
//  out     | o_out_valid / i_out_ready | o_quantity, o_crc_ok, o_value[14:0]
//
// One byte transaction per cycle is accepted while the queue has room; the
// result shows on o_out_valid after the group's CRC byte passes the queue
// write at its accepting edge, the multiply stage and the output register.
// Each group's CRC byte yields a result; other bytes only update CRC and word.
// Reset is synchronous, active low; no clearing pass, o_in_ready is high from
// the first cycle out of reset.
// An output stall backs up the back end first, then the queue, and only
// drops o_in_ready when the queue is full.
`default_nettype none

module humidity_sensor_readout_decoder #(
    parameter int QDEPTH = hsrd_pkg::HSRD_QDEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [7:0]          i_rx_byte,
    input  wire                 i_frame_start,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_quantity,
    output logic                o_crc_ok,
    output logic signed [14:0]  o_value
);
    import hsrd_pkg::*;

    logic      in_accept;
    logic      push;
    t_grp_item push_item;
    logic      q_push_ready;
    logic      q_pop_valid;
    t_grp_item q_pop_item;
    logic      back_ready;

    // A byte is only held back when the queue cannot take a finished group.
    assign o_in_ready = q_push_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // front: position, CRC accumulation, word assembly
    hsrd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_push        (push),
        .o_push_item   (push_item)
    );

    // decoupling queue of completed groups
    hsrd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_item  (push_item),
        .o_push_ready (q_push_ready),
        .o_pop_valid  (q_pop_valid),
        .o_pop_item   (q_pop_item),
        .i_pop        (back_ready)
    );

    // back: conversion, held values, result register
    hsrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_pop_valid),
        .i_item      (q_pop_item),
        .o_ready     (back_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_quantity  (o_quantity),
        .o_crc_ok    (o_crc_ok),
        .o_value     (o_value)
    );

endmodule

`default_nettype wire

### rtl/hsrd_checker.sv
// hsrd_checker: port-level assertions for the readout decoder, bound to the top.
// Depends on humidity_sensor_readout_decoder (bind target).
`default_nettype none

module hsrd_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_ready,
    input wire  [7:0]         i_rx_byte,
    input wire                i_frame_start,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input wire                o_quantity,
    input wire                o_crc_ok,
    input wire signed [14:0]  o_value
);
    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value)
            && $stable(o_quantity) && $stable(o_crc_ok))
        else $error("result changed while stalled");

    // humidity results stay within 0.00 .. 99.99 %
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_quantity |-> o_value >= 15'sd0 && o_value <= 15'sd9999)
        else $error("humidity out of range");

    // temperature results stay within -45.00 .. 129.99 degrees
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_quantity |-> o_value >= -15'sd4500 && o_value <= 15'sd12999)
        else $error("temperature out of range");

    // no result is shown in the cycle right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid out of reset");

endmodule

bind humidity_sensor_readout_decoder hsrd_checker u_hsrd_checker (.*);

`default_nettype wire

### tb/humidity_sensor_readout_decoder_chk.sv
// Checker for the sensor readout decoder: watches both channels, predicts each
// reading from the accepted bytes and compares. Depends on hsrd_pkg.
`timescale 1ns / 100ps

module humidity_sensor_readout_decoder_chk (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_frame_start,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire         i_quantity,
    input  wire         i_crc_ok,
    input  wire  [14:0] i_value,
    output int          o_fail_count,
    output int          o_readings_pending,
    output int          o_readings_checked,
    output int          o_bad_crc_readings,
    output int          o_input_stall_cycles
);

    localparam logic [7:0]  CRC_SEED      = 8'hFF;
    localparam logic [7:0]  CRC_TAPS      = 8'h31;
    localparam logic [15:0] STATUS_BITS   = 16'h0003;

    typedef struct packed {
        logic        quantity;
        logic        crc_ok;
        logic [14:0] value;
    } reading_t;

    reading_t expected_readings[$];

    // decoder state as the byte stream sees it
    logic [2:0]  byte_pos;
    logic [7:0]  group_crc;
    logic [15:0] word_acc;
    logic [14:0] temp_held;
    logic [13:0] hum_held;

    int mismatches    = 0;
    int checked       = 0;
    int bad_crc       = 0;
    int stall_cycles  = 0;

    initial begin
        o_fail_count         = 0;
        o_readings_pending   = 0;
        o_readings_checked   = 0;
        o_bad_crc_readings   = 0;
        o_input_stall_cycles = 0;
    end

    // serial form of the CRC-8: one message bit at a time, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       feedback;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            feedback = r[7] ^ data[i];
            r = {r[6:0], 1'b0};
            if (feedback) begin
                r = r ^ CRC_TAPS;
            end
        end
        return r;
    endfunction

    function automatic logic [14:0] temp_centi(input logic [15:0] word);
        longint unsigned raw;
        longint unsigned scaled;
        logic [14:0]     result;
        raw    = 64'(word & ~STATUS_BITS);
        scaled = (64'd17500 * raw) / 64'd65535;
        result = 15'(scaled - 64'd4500);   // wraps to 15-bit two's complement
        return result;
    endfunction

    function automatic logic [13:0] hum_centi(input logic [15:0] word);
        longint unsigned raw;
        longint unsigned scaled;
        logic [13:0]     result;
        raw    = 64'(word & ~STATUS_BITS);
        scaled = (64'd10000 * raw) / 64'd65535;
        result = 14'(scaled);
        return result;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        reading_t   got;
        reading_t   want;
        logic [2:0] pos;
        logic       match;
        if (!i_rst_n) begin
            byte_pos  = 3'd0;
            group_crc = CRC_SEED;
            word_acc  = 16'h0000;
            temp_held = '0;
            hum_held  = '0;
        end else begin
            // result side first; a result never leaves in the cycle its byte arrives
            if (i_out_valid && i_out_ready) begin
                got.quantity = i_quantity;
                got.crc_ok   = i_crc_ok;
                got.value    = i_value;
                checked++;
                if (!got.crc_ok) begin
                    bad_crc++;
                end
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("unexpected reading q=%0b ok=%0b v=%0d",
                                              got.quantity, got.crc_ok, $signed(got.value)));
                end else begin
                    want = expected_readings.pop_front();
                    if (got.quantity !== want.quantity) begin
                        report_mismatch($sformatf("quantity got %0b want %0b",
                                                  got.quantity, want.quantity));
                    end
                    if (got.crc_ok !== want.crc_ok) begin
                        report_mismatch($sformatf("crc_ok got %0b want %0b (q=%0b)",
                                                  got.crc_ok, want.crc_ok, want.quantity));
                    end
                    if (got.value !== want.value) begin
                        report_mismatch($sformatf("value got %0d want %0d (q=%0b)",
                                                  $signed(got.value), $signed(want.value),
                                                  want.quantity));
                    end
                end
            end

            if (i_in_valid && !i_in_ready) begin
                stall_cycles++;
            end

            if (i_in_valid && i_in_ready) begin
                pos = i_frame_start ? 3'd0 : byte_pos;
                if (pos > 3'd5) begin
                    pos = 3'd0;
                end
                case (pos)
                    3'd0, 3'd3: begin
                        group_crc      = crc8_step(CRC_SEED, i_rx_byte);
                        word_acc[15:8] = i_rx_byte;
                        byte_pos       = pos + 3'd1;
                    end
                    3'd1, 3'd4: begin
                        group_crc     = crc8_step(group_crc, i_rx_byte);
                        word_acc[7:0] = i_rx_byte;
                        byte_pos      = pos + 3'd1;
                    end
                    default: begin
                        match       = (group_crc == i_rx_byte);
                        want.crc_ok = match;
                        if (pos == 3'd2) begin
                            if (match) begin
                                temp_held = temp_centi(word_acc);
                            end
                            want.quantity = hsrd_pkg::QTY_TEMP;
                            want.value    = temp_held;
                        end else begin
                            if (match) begin
                                hum_held = hum_centi(word_acc);
                            end
                            want.quantity = hsrd_pkg::QTY_HUM;
                            want.value    = {1'b0, hum_held};
                        end
                        expected_readings.push_back(want);
                        group_crc = CRC_SEED;
                        byte_pos  = (pos == 3'd5) ? 3'd0 : pos + 3'd1;
                    end
                endcase
            end
        end

        o_fail_count         <= mismatches;
        o_readings_pending   <= expected_readings.size();
        o_readings_checked   <= checked;
        o_bad_crc_readings   <= bad_crc;
        o_input_stall_cycles <= stall_cycles;
    end

endmodule

### tb/humidity_sensor_readout_decoder_tb.sv
// Testbench top for the sensor readout decoder: feeds readback byte streams
// (good, corrupted, truncated and noise) with random idling on both channels
// and gives the verdict. Depends on the decoder top and the checker module.
`timescale 1ns / 100ps

module humidity_sensor_readout_decoder_tb;

    localparam int ITEM_TARGET   = 1050;     // bytes to offer in total
    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int SETTLE_CYCLES = 20;       // well past the queue and back end
    localparam int LIMIT_CYCLES  = 500000;   // generous watchdog

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  rx_byte     = 8'h00;
    logic        frame_start = 1'b0;
    logic        out_ready   = 1'b0;

    wire               in_ready;
    wire               out_valid;
    wire               quantity;
    wire               crc_ok;
    wire signed [14:0] value;

    int fail_count;
    int readings_pending;
    int readings_checked;
    int bad_crc_readings;
    int input_stall_cycles;

    int cycle_count  = 0;
    int bytes_sent   = 0;
    bit tx_burst     = 1'b0;   // sender stretch with no idle cycles
    bit rx_burst     = 1'b0;   // receiver stretch with no stalls
    bit hold_request = 1'b0;   // asks the receiver for one long hold-off

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    humidity_sensor_readout_decoder u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_rx_byte     (rx_byte),
        .i_frame_start (frame_start),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_quantity    (quantity),
        .o_crc_ok      (crc_ok),
        .o_value       (value)
    );

    humidity_sensor_readout_decoder_chk u_chk (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_rx_byte            (rx_byte),
        .i_frame_start        (frame_start),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_quantity           (quantity),
        .i_crc_ok             (crc_ok),
        .i_value              (value),
        .o_fail_count         (fail_count),
        .o_readings_pending   (readings_pending),
        .o_readings_checked   (readings_checked),
        .o_bad_crc_readings   (bad_crc_readings),
        .o_input_stall_cycles (input_stall_cycles)
    );

    // Watchdog: a hung handshake or a lost reading ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // CRC over a whole 16-bit word, bit-serial; only used to build stimulus
    function automatic logic [7:0] word_crc(input logic [15:0] word);
        logic [7:0] r;
        logic       feedback;
        r = 8'hFF;
        for (int i = 15; i >= 0; i--) begin
            feedback = r[7] ^ word[i];
            r = {r[6:0], 1'b0};
            if (feedback) begin
                r = r ^ 8'h31;
            end
        end
        return r;
    endfunction

    // Word picker: extremes and status-bit corners now and then, else uniform.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0003;
            3:       return 16'hFFFC;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One byte transaction. Valid drops only when an idle gap is drawn, so a
    // back-to-back byte keeps valid high with a single assignment per edge.
    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= data;
        frame_start <= start;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Readback of up to six bytes: temperature group then humidity group.
    // A failing group gets one random bit of its CRC flipped; count < 6 cuts
    // the readback short.
    task automatic send_readback(input logic [15:0] t_word, input logic [15:0] h_word,
                                 input bit t_good, input bit h_good,
                                 input bit with_start, input int count);
        logic [7:0] frame [6];
        frame[0] = t_word[15:8];
        frame[1] = t_word[7:0];
        frame[2] = word_crc(t_word) ^ (t_good ? 8'h00 : (8'h01 << $urandom_range(0, 7)));
        frame[3] = h_word[15:8];
        frame[4] = h_word[7:0];
        frame[5] = word_crc(h_word) ^ (h_good ? 8'h00 : (8'h01 << $urandom_range(0, 7)));
        for (int i = 0; i < count; i++) begin
            send_byte(frame[i], with_start && (i == 0));
        end
    endtask

    // Sender goes quiet until every predicted reading has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0) @(posedge clk);
    endtask

    // Receiver: random stall per reading, occasional no-stall stretches, and
    // one long hold-off on request so the queue fills and in_ready drops.
    initial begin : receiver
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 15) == 0) begin
                rx_burst = !rx_burst;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        int sel;
        bit hold_done;
        hold_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // both checks fail before any good word: reset values come back
        send_readback(16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1, 6);
        // coldest temperature, wettest humidity (status bits cleared)
        send_readback(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 6);
        // no frame_start: position wrapped after the last readback
        send_readback(16'hFFFF, 16'h0003, 1'b1, 1'b1, 1'b0, 6);
        // cut short after the humidity high byte, then a restart mid-readback;
        // the failed temperature check reports the value held from before
        send_readback(16'h8001, 16'h7FFE, 1'b1, 1'b1, 1'b1, 4);
        send_readback(16'hFFFC, 16'h0000, 1'b0, 1'b1, 1'b1, 6);
        drain_results();

        // --- random ---
        while (bytes_sent < ITEM_TARGET) begin
            if (!hold_done && bytes_sent >= ITEM_TARGET / 2) begin
                // receiver sits still while the sender streams full readbacks
                hold_request = 1'b1;
                tx_burst     = 1'b1;
                repeat (10) begin
                    send_readback(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1, 6);
                end
                tx_burst  = 1'b0;
                drain_results();
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                tx_burst = !tx_burst;
            end
            sel = $urandom_range(0, 99);
            if (sel < 72) begin
                // well-formed readback, mostly good CRCs, sometimes no frame_start
                send_readback(pick_word(), pick_word(),
                              $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                              $urandom_range(0, 9) != 0, 6);
            end else if (sel < 86) begin
                // truncated readback, abandoned partway
                send_readback(pick_word(), pick_word(), 1'b1, 1'b1, 1'b1,
                              $urandom_range(1, 5));
            end else begin
                // raw noise with stray frame_start marks
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d bytes sent, %0d readings checked, %0d of them with a failed CRC.",
                 bytes_sent, readings_checked, bad_crc_readings);
        $display("Input back-pressure seen on %0d cycles; one receiver hold-off of %0d cycles.",
                 input_stall_cycles, HOLD_CYCLES);
        if (fail_count == 0 && readings_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
